// ----- hdl/sdlcp_pkg.sv -----
package sdlcp_pkg;

  localparam int COLUMNS     = 16;
  localparam int STORE_DEPTH = COLUMNS - 1;
  localparam int CNT_W       = $clog2(COLUMNS);
  localparam int IDX_W       = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

  localparam logic [7:0] BYTE_ZERO       = 8'h00;
  localparam logic [7:0] BYTE_LED_OFF_HI = 8'h03;
  localparam logic [7:0] BYTE_NL         = 8'h0A;
  localparam logic [7:0] BYTE_LED_ON_LO  = 8'h10;
  localparam logic [7:0] BYTE_LED_ON_HI  = 8'h13;
  localparam logic [7:0] BYTE_SPACE      = 8'h20;
  localparam logic [7:0] BYTE_TOP        = 8'h21;
  localparam logic [7:0] BYTE_BOT        = 8'h22;

  localparam logic       KIND_LED  = 1'b0;
  localparam logic       KIND_CELL = 1'b1;
  localparam logic [2:0] ROW_TOP   = 3'd0;
  localparam logic [2:0] ROW_BOT   = 3'd2;

  typedef struct packed {
    logic idle_byte;
    logic cap_byte;
    logic col_clr;
    logic emit_blank;
    logic emit_text;
    logic line_end;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
    logic is_nl;
    logic is_start;
    logic cnt_zero;
    logic col_end;
    logic text_last;
  } dp_sts_t;

endpackage

// ----- hdl/sdlcp_if.sv -----
interface sdlcp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface sdlcp_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [3:0] led_mask;
  logic [2:0] row;
  logic [3:0] column;
  logic [7:0] glyph;
  logic       last;

  modport source (output valid, output kind, output led_mask, output row,
                  output column, output glyph, output last, input ready);
  modport sink (input valid, input kind, input led_mask, input row,
                input column, input glyph, input last, output ready);
endinterface

// ----- hdl/sdlcp_dp.sv -----
module sdlcp_dp import sdlcp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  dp_cmd_t           cmd,
  input  logic [7:0]        rx_byte,
  output dp_sts_t           sts,
  sdlcp_out_if.source       out_ch
);

  logic             row_bot_r;
  logic [CNT_W-1:0] cnt_r;
  logic             zs_r;
  logic [3:0]       led_r, led_nxt;
  logic [CNT_W-1:0] col_r;
  logic [CNT_W-1:0] col_p1;
  logic [7:0]       store_r [STORE_DEPTH];

  logic             out_valid_r;
  logic             kind_r;
  logic [3:0]       mask_r;
  logic [2:0]       row_r;
  logic [3:0]       column_r;
  logic [7:0]       glyph_r;
  logic             last_r;

  logic             led_on, led_off, led_load, store_wr;
  logic [2:0]       cur_row;

  assign led_on   = (rx_byte >= BYTE_LED_ON_LO) && (rx_byte <= BYTE_LED_ON_HI);
  assign led_off  = (rx_byte <= BYTE_LED_OFF_HI);
  assign led_load = cmd.idle_byte && (led_on || led_off);
  assign store_wr = cmd.cap_byte && (rx_byte != BYTE_ZERO) && !zs_r &&
                    (cnt_r < CNT_W'(STORE_DEPTH));
  assign col_p1   = col_r + CNT_W'(1);
  assign cur_row  = row_bot_r ? ROW_BOT : ROW_TOP;

  // slot index is the low two bits for both on and off codes
  always_comb begin
    led_nxt = led_r;
    if (cmd.idle_byte && led_on) begin
      led_nxt = led_r | (4'b0001 << rx_byte[1:0]);
    end else if (cmd.idle_byte && led_off) begin
      led_nxt = led_r & ~(4'b0001 << rx_byte[1:0]);
    end
  end

  always_comb begin
    sts.out_free  = !out_valid_r || out_ch.ready;
    sts.is_nl     = (rx_byte == BYTE_NL);
    sts.is_start  = (rx_byte == BYTE_TOP) || (rx_byte == BYTE_BOT);
    sts.cnt_zero  = (cnt_r == '0);
    sts.col_end   = (col_r == CNT_W'(COLUMNS - 1));
    sts.text_last = ({1'b0, col_r} + (CNT_W+1)'(1)) == {1'b0, cnt_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_bot_r   <= 1'b0;
      cnt_r       <= '0;
      zs_r        <= 1'b0;
      led_r       <= '0;
      col_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      led_r <= led_nxt;
      if (cmd.idle_byte && sts.is_start) begin
        row_bot_r <= (rx_byte == BYTE_BOT);
        cnt_r     <= '0;
        zs_r      <= 1'b0;
      end
      if (cmd.cap_byte && (rx_byte == BYTE_ZERO)) begin
        zs_r <= 1'b1;
      end
      if (store_wr) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
      if (cmd.line_end) begin
        cnt_r <= '0;
        zs_r  <= 1'b0;
      end
      if (cmd.col_clr) begin
        col_r <= '0;
      end else if (cmd.emit_blank || cmd.emit_text) begin
        col_r <= col_p1;
      end
      if (led_load || cmd.emit_blank || cmd.emit_text) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // line store and result payload
  always_ff @(posedge clk) begin
    if (store_wr) begin
      store_r[cnt_r[IDX_W-1:0]] <= rx_byte;
    end
    if (led_load) begin
      kind_r   <= KIND_LED;
      mask_r   <= led_nxt;
      row_r    <= ROW_TOP;
      column_r <= 4'd0;
      glyph_r  <= 8'd0;
      last_r   <= 1'b1;
    end else if (cmd.emit_blank) begin
      kind_r   <= KIND_CELL;
      mask_r   <= led_r;
      row_r    <= cur_row;
      column_r <= 4'(col_r);
      glyph_r  <= BYTE_SPACE;
      last_r   <= sts.col_end && sts.cnt_zero;
    end else if (cmd.emit_text) begin
      kind_r   <= KIND_CELL;
      mask_r   <= led_r;
      row_r    <= cur_row;
      column_r <= 4'(col_p1);
      glyph_r  <= store_r[col_r[IDX_W-1:0]];
      last_r   <= sts.text_last;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.kind     = kind_r;
  assign out_ch.led_mask = mask_r;
  assign out_ch.row      = row_r;
  assign out_ch.column   = column_r;
  assign out_ch.glyph    = glyph_r;
  assign out_ch.last     = last_r;

endmodule

// ----- hdl/sdlcp_ctrl.sv -----
module sdlcp_ctrl import sdlcp_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CAP   = 2'd1;
  localparam logic [1:0] S_BLANK = 2'd2;
  localparam logic [1:0] S_TEXT  = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       xfer;

  assign in_ready = ((state_r == S_IDLE) || (state_r == S_CAP)) && sts.out_free;
  assign xfer     = in_valid && in_ready;

  always_comb begin
    cmd.idle_byte  = xfer && (state_r == S_IDLE);
    cmd.cap_byte   = xfer && (state_r == S_CAP) && !sts.is_nl;
    cmd.emit_blank = (state_r == S_BLANK) && sts.out_free;
    cmd.emit_text  = (state_r == S_TEXT) && sts.out_free;
    cmd.col_clr    = (xfer && (state_r == S_CAP) && sts.is_nl) ||
                     (cmd.emit_blank && sts.col_end);
    cmd.line_end   = (cmd.emit_blank && sts.col_end && sts.cnt_zero) ||
                     (cmd.emit_text && sts.text_last);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (xfer && sts.is_start) state_nxt = S_CAP;
      end
      S_CAP: begin
        if (xfer && sts.is_nl) state_nxt = S_BLANK;
      end
      S_BLANK: begin
        if (cmd.emit_blank && sts.col_end) begin
          state_nxt = sts.cnt_zero ? S_IDLE : S_TEXT;
        end
      end
      S_TEXT: begin
        if (cmd.emit_text && sts.text_last) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_no_input_during_burst: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_BLANK) || (state_r == S_TEXT)) |-> !in_ready)
    else $error("input taken while a line is being written");

  a_text_has_chars: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TEXT) |-> !sts.cnt_zero)
    else $error("text phase entered with an empty line");

  a_empty_line_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_blank && sts.col_end && sts.cnt_zero) |=> (state_r == S_IDLE))
    else $error("empty line did not return to idle after blanking");

endmodule

// ----- hdl/serial_display_led_command_parser.sv -----
// channel  direction  payload
// in_ch    sink       rx_byte[7:0]
// out_ch   source     kind, led_mask[3:0], row[2:0], column[3:0], glyph[7:0], last
//
// An LED command loads the output register as it is accepted. A newline starts a burst of
// COLUMNS space writes plus one write per stored character, one transfer per cycle while
// out_ch is not stalled, paced by the single output register; in_ch is held off meanwhile.
// rst_n is synchronous, active low: idle, top row, LEDs off, empty line.
// A stalled out_ch blocks further input until the output register is free.
module serial_display_led_command_parser import sdlcp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  sdlcp_in_if.sink    in_ch,
  sdlcp_out_if.source out_ch
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  sdlcp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sdlcp_dp u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .rx_byte (in_ch.rx_byte),
    .sts     (sts),
    .out_ch  (out_ch)
  );

endmodule
